// ----- hdl/lrl_pkg.sv -----
// Shared types, constants and helper functions for the LPM route lookup block.
// No dependencies; the other files that use it refer to it by scoped names.
package lrl_pkg;

	// Table geometry
	localparam int ROUTE_ENTRIES = 64;
	localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

	// Command codes
	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_FORWARD = 1'b1
	} cmd_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_FORWARDED = 3'd0,
		ST_EXPIRED   = 3'd1,
		ST_NO_ROUTE  = 3'd2,
		ST_INSERTED  = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// Input word
	typedef struct packed {
		cmd_t        command;
		logic [31:0] dest_addr;
		logic [7:0]  ttl_in;
		logic [31:0] route_network;
		logic [31:0] route_mask;
		logic [31:0] route_hop;
	} in_word_t;

	// Result word
	typedef struct packed {
		status_t     status;
		logic [7:0]  ttl_out;
		logic [31:0] hop_addr;
		logic [5:0]  prefix_len;
		logic [5:0]  entry_index;
	} out_word_t;

	// One stored route
	typedef struct packed {
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [5:0]  plen;
	} route_ent_t;

	localparam int ENT_W = $bits(route_ent_t);

	// Best match so far, kept by the compare unit
	typedef struct packed {
		logic             found;
		logic [5:0]       plen;
		logic [IDX_W-1:0] idx;
		logic [31:0]      hop;
	} best_t;

	// Prefix length of a mask: number of set bits
	function automatic logic [5:0] ones_in(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int b = 0; b < 32; b++) begin
			n = n + {5'd0, v[b]};
		end
		return n;
	endfunction

	// Table index folded into the 6-bit result field (modulo 64)
	function automatic logic [5:0] idx_field(input logic [IDX_W-1:0] idx);
		logic [IDX_W+5:0] wide;
		wide = {6'd0, idx};
		return wide[5:0];
	endfunction

endpackage

// ----- hdl/lrl_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module lrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- hdl/lrl_match.sv -----
// Shared compare unit: tests one table entry per cycle against the destination
// and keeps the longest-prefix hit seen so far. Depends on lrl_pkg.
module lrl_match (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic                      vld,
	input  logic [31:0]               dest,
	input  lrl_pkg::route_ent_t       ent,
	input  logic [lrl_pkg::IDX_W-1:0] idx,
	output lrl_pkg::best_t            best
);

	lrl_pkg::best_t best_q;
	logic           hit;
	logic           better;

	// Exact masked compare, then strictly longer prefix (first hit always wins)
	assign hit    = ((dest & ent.mask) == ent.net);
	assign better = !best_q.found || (ent.plen > best_q.plen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clr) begin
			best_q <= '0;
		end else if (vld && hit && better) begin
			best_q <= '{found: 1'b1, plen: ent.plen, idx: idx, hop: ent.hop};
		end
	end

	assign best = best_q;

endmodule

// ----- hdl/lpm_route_lookup_ttl_top.sv -----
// IPv4 longest-prefix-match route table: insert and forward commands.
// An insert or an expired TTL is answered in the next cycle; a forward scans all
// stored routes through one RAM read port and one compare unit, one entry
// per cycle, and answers once the last compare has landed.
// busy is high during the scan. done pulses for one cycle with rsp valid;
// results cannot be held off. No clearing pass after reset is needed.
// Depends on lrl_pkg, lrl_ram, lrl_match.
module lpm_route_lookup_ttl_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lrl_pkg::in_word_t  req,
	output logic               done,
	output lrl_pkg::out_word_t rsp
);

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	state_t                    state_q;
	logic [lrl_pkg::CNT_W-1:0] count_q;
	logic [lrl_pkg::CNT_W-1:0] issue_q;
	logic                      vld_s1;
	logic [lrl_pkg::IDX_W-1:0] idx_s1;
	logic [31:0]               dest_q;
	logic [7:0]                ttl_q;
	logic                      done_q;
	lrl_pkg::out_word_t        rsp_q;

	logic                      accept;
	logic                      room;
	logic                      we;
	logic                      scan_clr;
	logic                      quick;
	logic                      scan_end;
	logic [lrl_pkg::IDX_W-1:0] addr;
	lrl_pkg::route_ent_t       wr_ent;
	logic [lrl_pkg::ENT_W-1:0] rdata;
	lrl_pkg::route_ent_t       rd_ent;
	lrl_pkg::best_t            best;
	lrl_pkg::out_word_t        quick_rsp;
	lrl_pkg::out_word_t        scan_rsp;

	// Handshake and table write
	assign accept = start && (state_q == S_IDLE);
	assign room   = (count_q < lrl_pkg::CNT_W'(lrl_pkg::ROUTE_ENTRIES));
	assign we     = accept && (req.command == lrl_pkg::CMD_INSERT) && room;
	assign scan_clr = accept && (req.command == lrl_pkg::CMD_FORWARD)
		&& (req.ttl_in != 8'd0);
	assign quick  = accept && ((req.command == lrl_pkg::CMD_INSERT)
		|| (req.ttl_in == 8'd0));
	assign scan_end = (state_q == S_SCAN) && !(issue_q < count_q) && !vld_s1;
	assign addr   = we ? count_q[lrl_pkg::IDX_W-1:0] : issue_q[lrl_pkg::IDX_W-1:0];

	always_comb begin
		wr_ent.net  = req.route_network;
		wr_ent.mask = req.route_mask;
		wr_ent.hop  = req.route_hop;
		wr_ent.plen = lrl_pkg::ones_in(req.route_mask);
	end

	// Quick answers: insert, table full, expired
	always_comb begin
		quick_rsp = '0;
		if (req.command == lrl_pkg::CMD_INSERT) begin
			if (room) begin
				quick_rsp.status      = lrl_pkg::ST_INSERTED;
				quick_rsp.prefix_len  = wr_ent.plen;
				quick_rsp.entry_index =
					lrl_pkg::idx_field(count_q[lrl_pkg::IDX_W-1:0]);
			end else begin
				quick_rsp.status = lrl_pkg::ST_FULL;
			end
		end else begin
			quick_rsp.status = lrl_pkg::ST_EXPIRED;
		end
	end

	// Answer at the end of a scan
	always_comb begin
		scan_rsp         = '0;
		scan_rsp.ttl_out = ttl_q;
		if (best.found) begin
			scan_rsp.status      = lrl_pkg::ST_FORWARDED;
			scan_rsp.hop_addr    = best.hop;
			scan_rsp.prefix_len  = best.plen;
			scan_rsp.entry_index = lrl_pkg::idx_field(best.idx);
		end else begin
			scan_rsp.status = lrl_pkg::ST_NO_ROUTE;
		end
	end

	// Route table storage
	lrl_ram #(
		.WIDTH(lrl_pkg::ENT_W),
		.DEPTH(lrl_pkg::ROUTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(wr_ent),
		.rdata(rdata)
	);

	assign rd_ent = lrl_pkg::route_ent_t'(rdata);

	// Shared compare unit
	lrl_match u_match (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (scan_clr),
		.vld   (vld_s1),
		.dest  (dest_q),
		.ent   (rd_ent),
		.idx   (idx_s1),
		.best  (best)
	);

	// Sequencer, counters and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			dest_q  <= '0;
			ttl_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= quick || scan_end;
			if (quick) begin
				rsp_q <= quick_rsp;
			end else if (scan_end) begin
				rsp_q <= scan_rsp;
			end
			case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (we) begin
						count_q <= count_q + 1'b1;
					end
					if (scan_clr) begin
						dest_q  <= req.dest_addr;
						ttl_q   <= req.ttl_in - 8'd1;
						issue_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_q < count_q) begin
						// read one entry; its data meets the compare next cycle
						vld_s1  <= 1'b1;
						idx_s1  <= issue_q[lrl_pkg::IDX_W-1:0];
						issue_q <= issue_q + 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							// last compare has landed
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- hdl/lrl_chk.sv -----
// Port-level checker for the LPM route lookup top level, bound to it below.
// Depends on lrl_pkg and lpm_route_lookup_ttl_top.
module lrl_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input lrl_pkg::in_word_t  req,
	input logic               done,
	input lrl_pkg::out_word_t rsp
);

	// A live forward always starts a scan
	a_fwd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.command == lrl_pkg::CMD_FORWARD && req.ttl_in != 8'd0
		|=> busy)
		else $error("forward with live ttl did not start a scan");

	// Inserts and expired packets answer on the next cycle
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.command == lrl_pkg::CMD_INSERT || req.ttl_in == 8'd0)
		|=> done && !busy)
		else $error("insert or expired word not answered in one cycle");

	// End of a scan always comes with a result
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && (rsp.status == lrl_pkg::ST_FORWARDED
		|| rsp.status == lrl_pkg::ST_NO_ROUTE))
		else $error("scan ended without a forward result");

	// Unused fields are zero on an expired packet
	a_expired_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == lrl_pkg::ST_EXPIRED |-> rsp.ttl_out == 8'd0
		&& rsp.hop_addr == 32'd0 && rsp.prefix_len == 6'd0 && rsp.entry_index == 6'd0)
		else $error("expired result carries nonzero fields");

endmodule

bind lpm_route_lookup_ttl_top lrl_chk u_lrl_chk (.*);
